// ----- hw/rtl/wvs_pkg.sv -----
package wvs_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int VRT_FRAC_DEF  = 16;

	localparam int ID_W     = 8;
	localparam int BURST_W  = 16;
	localparam int PRIO_W   = 4;
	localparam int VRT_W    = 48;
	localparam int SEQ_W    = 16;
	localparam int TICK_W   = 32;
	localparam int KIND_W   = 2;
	localparam int OVL_W    = 4;
	localparam int SHIFT_W  = 56;
	localparam int PRIO_NUM = 16;

	localparam logic [VRT_W-1:0] VRT_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_IDLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVL  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_FULL = 2'd3;

	localparam logic MODE_ADMIT = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic               vld;
		logic               found;
		logic [VRT_W-1:0]   vr;
		logic [SEQ_W-1:0]   age;
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic               free_found;
		logic               any;
	} tok_t;

	typedef struct packed {
		logic               wr;
		logic               run;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [VRT_W-1:0]   vr;
		logic [SEQ_W-1:0]   seq;
		logic [VRT_W-1:0]   weight;
	} cmd_t;

	// round-half-up of 1.25^(p-1) * 2^frac
	function automatic logic [VRT_W-1:0] weight_of(input int unsigned p,
			input int unsigned frac);
		logic [63:0] num;
		logic [63:0] r;
		int unsigned sh;
		num = 64'd1 << frac;
		r   = '0;
		sh  = 0;
		if (p == 0) begin
			r = ((64'd8 << frac) + 64'd5) / 64'd10;
		end else begin
			for (int unsigned k = 1; k < p; k++) begin
				num = num * 64'd5;
			end
			sh = 2 * (p - 1);
			r  = ((num << 1) + (64'd1 << sh)) >> (sh + 1);
		end
		return r[VRT_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/wvs_cell.sv -----
module wvs_cell #(
	parameter int IDX_W = 4,
	parameter int IDX   = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wvs_pkg::tok_t               tok_in,
	input  logic [IDX_W-1:0]            best_idx_in,
	input  logic [IDX_W-1:0]            free_idx_in,
	output wvs_pkg::tok_t               tok_out,
	output logic [IDX_W-1:0]            best_idx_out,
	output logic [IDX_W-1:0]            free_idx_out,
	input  logic [wvs_pkg::SEQ_W-1:0]   seq_now,
	input  wvs_pkg::cmd_t               cmd,
	input  logic [IDX_W-1:0]            cmd_idx
);

	logic                        valid_q;
	logic [wvs_pkg::ID_W-1:0]    id_q;
	logic [wvs_pkg::BURST_W-1:0] rem_q;
	logic [wvs_pkg::PRIO_W-1:0]  prio_q;
	logic [wvs_pkg::VRT_W-1:0]   vr_q;
	logic [wvs_pkg::SEQ_W-1:0]   seq_q;

	wvs_pkg::tok_t               tok_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [IDX_W-1:0]            free_idx_q;

	logic [wvs_pkg::SEQ_W-1:0]   own_age;
	logic                        take_best;
	logic                        take_free;
	logic                        hit;
	logic [wvs_pkg::VRT_W:0]     vr_sum;

	assign own_age   = seq_now - seq_q;
	assign take_best = valid_q && (!tok_in.found || (vr_q < tok_in.vr) ||
		((vr_q == tok_in.vr) && (own_age > tok_in.age)));
	assign take_free = !valid_q && !tok_in.free_found;
	assign hit       = (cmd_idx == IDX_W'(IDX));
	assign vr_sum    = {1'b0, vr_q} + {1'b0, cmd.weight};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q      <= '0;
			best_idx_q <= '0;
			free_idx_q <= '0;
		end else begin
			tok_q      <= tok_in;
			tok_q.any  <= tok_in.any | valid_q;
			best_idx_q <= best_idx_in;
			free_idx_q <= free_idx_in;
			if (take_best) begin
				tok_q.found <= 1'b1;
				tok_q.vr    <= vr_q;
				tok_q.age   <= own_age;
				tok_q.id    <= id_q;
				tok_q.prio  <= prio_q;
				best_idx_q  <= IDX_W'(IDX);
			end
			if (take_free) begin
				tok_q.free_found <= 1'b1;
				free_idx_q       <= IDX_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hit && cmd.wr) begin
			valid_q <= 1'b1;
		end else if (hit && cmd.run && (rem_q <= wvs_pkg::BURST_W'(1))) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.wr) begin
			id_q   <= cmd.id;
			rem_q  <= cmd.burst;
			prio_q <= cmd.prio;
			vr_q   <= cmd.vr;
			seq_q  <= cmd.seq;
		end else if (hit && cmd.run) begin
			vr_q  <= vr_sum[wvs_pkg::VRT_W] ? wvs_pkg::VRT_MAX : vr_sum[wvs_pkg::VRT_W-1:0];
			rem_q <= (rem_q <= wvs_pkg::BURST_W'(1)) ? '0 : rem_q - wvs_pkg::BURST_W'(1);
		end
	end

	assign tok_out      = tok_q;
	assign best_idx_out = best_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

// ----- hw/rtl/wvs_ctrl.sv -----
module wvs_ctrl #(
	parameter int IDX_W         = 4,
	parameter int VRT_FRAC_BITS = wvs_pkg::VRT_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [wvs_pkg::ID_W-1:0]     proc_id,
	input  logic [wvs_pkg::BURST_W-1:0]  burst_ticks,
	input  logic [wvs_pkg::PRIO_W-1:0]   priority_level,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wvs_pkg::KIND_W-1:0]   slot_kind,
	output logic [wvs_pkg::ID_W-1:0]     run_id,
	output logic                         last_of_run,
	input  logic                         cfg_wr_en,
	input  logic [wvs_pkg::OVL_W-1:0]    cfg_wr_data,
	output wvs_pkg::tok_t                tok_start,
	input  wvs_pkg::tok_t                tok_end,
	input  logic [IDX_W-1:0]             best_idx_end,
	input  logic [IDX_W-1:0]             free_idx_end,
	output wvs_pkg::cmd_t                cmd,
	output logic [IDX_W-1:0]             cmd_idx,
	output logic [wvs_pkg::SEQ_W-1:0]    seq_now
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	localparam int F = VRT_FRAC_BITS;
	localparam logic [wvs_pkg::VRT_W-1:0] WEIGHT_TBL [wvs_pkg::PRIO_NUM] = '{
		wvs_pkg::weight_of(0, F),  wvs_pkg::weight_of(1, F),
		wvs_pkg::weight_of(2, F),  wvs_pkg::weight_of(3, F),
		wvs_pkg::weight_of(4, F),  wvs_pkg::weight_of(5, F),
		wvs_pkg::weight_of(6, F),  wvs_pkg::weight_of(7, F),
		wvs_pkg::weight_of(8, F),  wvs_pkg::weight_of(9, F),
		wvs_pkg::weight_of(10, F), wvs_pkg::weight_of(11, F),
		wvs_pkg::weight_of(12, F), wvs_pkg::weight_of(13, F),
		wvs_pkg::weight_of(14, F), wvs_pkg::weight_of(15, F)
	};

	logic [1:0]                   state_q;
	logic                         mode_q;
	logic [wvs_pkg::ID_W-1:0]     pid_q;
	logic [wvs_pkg::BURST_W-1:0]  burst_q;
	logic [wvs_pkg::PRIO_W-1:0]   prio_q;
	logic [wvs_pkg::TICK_W-1:0]   tick_q;
	logic [wvs_pkg::SEQ_W-1:0]    seq_q;
	logic [wvs_pkg::ID_W-1:0]     cur_id_q;
	logic                         cur_valid_q;
	logic [wvs_pkg::OVL_W-1:0]    ovl_q;
	wvs_pkg::cmd_t                cmd_q;
	logic [IDX_W-1:0]             cmd_idx_q;
	logic [wvs_pkg::KIND_W-1:0]   emit_kind_q;
	logic [wvs_pkg::ID_W-1:0]     emit_id_q;
	logic [wvs_pkg::OVL_W-1:0]    emit_left_q;
	logic                         out_valid_q;
	logic [wvs_pkg::KIND_W-1:0]   out_kind_q;
	logic [wvs_pkg::ID_W-1:0]     out_id_q;
	logic                         out_last_q;

	logic                         accept;
	logic                         done;
	logic                         out_free;
	logic [wvs_pkg::SHIFT_W-1:0]  tick_sh;
	logic [wvs_pkg::VRT_W-1:0]    admit_vr;

	assign in_stall = (state_q != ST_IDLE) || cmd_q.wr;
	assign accept   = in_valid && !in_stall;
	assign done     = (state_q == ST_SWEEP) && tok_end.vld;
	assign out_free = !out_valid_q || !out_stall;
	assign tick_sh  = {{(wvs_pkg::SHIFT_W - wvs_pkg::TICK_W){1'b0}}, tick_q} << F;
	assign admit_vr = (|tick_sh[wvs_pkg::SHIFT_W-1:wvs_pkg::VRT_W]) ?
		wvs_pkg::VRT_MAX : tick_sh[wvs_pkg::VRT_W-1:0];

	always_comb begin
		tok_start     = '0;
		tok_start.vld = accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			pid_q   <= proc_id;
			burst_q <= burst_ticks;
			prio_q  <= priority_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovl_q <= '0;
		end else if (cfg_wr_en) begin
			ovl_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			seq_q       <= '0;
			cur_id_q    <= '0;
			cur_valid_q <= 1'b0;
			cmd_q       <= '0;
			cmd_idx_q   <= '0;
			emit_kind_q <= wvs_pkg::KIND_IDLE;
			emit_id_q   <= '0;
			emit_left_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= wvs_pkg::KIND_IDLE;
			out_id_q    <= '0;
			out_last_q  <= 1'b0;
		end else begin
			cmd_q.wr  <= 1'b0;
			cmd_q.run <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (done) begin
						emit_left_q <= wvs_pkg::OVL_W'(1);
						emit_id_q   <= '0;
						state_q     <= ST_EMIT;
						if (mode_q == wvs_pkg::MODE_ADMIT) begin
							if (!tok_end.free_found) begin
								emit_kind_q <= wvs_pkg::KIND_FULL;
								emit_id_q   <= pid_q;
							end else begin
								state_q     <= ST_IDLE;
								cmd_q.wr    <= 1'b1;
								cmd_q.id    <= pid_q;
								cmd_q.burst <= burst_q;
								cmd_q.prio  <= prio_q;
								cmd_q.vr    <= admit_vr;
								cmd_q.seq   <= seq_q;
								cmd_idx_q   <= free_idx_end;
								seq_q       <= seq_q + wvs_pkg::SEQ_W'(1);
								if (!tok_end.any) begin
									cur_id_q    <= pid_q;
									cur_valid_q <= 1'b1;
								end
							end
						end else begin
							tick_q <= tick_q + wvs_pkg::TICK_W'(1);
							if (!tok_end.found) begin
								emit_kind_q <= wvs_pkg::KIND_IDLE;
							end else if (!cur_valid_q || (tok_end.id != cur_id_q)) begin
								cur_id_q    <= tok_end.id;
								cur_valid_q <= 1'b1;
								emit_kind_q <= wvs_pkg::KIND_OVL;
								emit_left_q <= ovl_q;
								if (ovl_q == '0) begin
									state_q <= ST_IDLE;
								end
							end else begin
								emit_kind_q  <= wvs_pkg::KIND_RUN;
								emit_id_q    <= tok_end.id;
								cmd_q.run    <= 1'b1;
								cmd_q.weight <= WEIGHT_TBL[tok_end.prio];
								cmd_idx_q    <= best_idx_end;
							end
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= emit_kind_q;
						out_id_q    <= emit_id_q;
						out_last_q  <= (emit_left_q == wvs_pkg::OVL_W'(1));
						emit_left_q <= emit_left_q - wvs_pkg::OVL_W'(1);
						if (emit_left_q == wvs_pkg::OVL_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd         = cmd_q;
	assign cmd_idx     = cmd_idx_q;
	assign seq_now     = seq_q;
	assign out_valid   = out_valid_q;
	assign slot_kind   = out_kind_q;
	assign run_id      = out_id_q;
	assign last_of_run = out_last_q;

endmodule

// ----- hw/rtl/weighted_vruntime_scheduler.sv -----
// channel   direction  handshake            payload
// in        receive    in_valid / in_stall  mode, proc_id, burst_ticks, priority_level
// out       send       out_valid / out_stall slot_kind, run_id, last_of_run
// cfg       receive    cfg_wr_en            cfg_wr_data (overload_slots)
//
// Every item runs one sweep token through the chain of MAX_PROCS cells, one cell per cycle;
// no new item is taken until the sweep ends and its results are issued.
// A switch with N overload slots emits N overload results.
// Reset clears the valid bit of every cell at once; no clearing pass.
// out_stall holds the output register; the next item is still taken while a result waits.
module weighted_vruntime_scheduler #(
	parameter int MAX_PROCS     = wvs_pkg::MAX_PROCS_DEF,
	parameter int VRT_FRAC_BITS = wvs_pkg::VRT_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic [wvs_pkg::ID_W-1:0]     proc_id,
	input  logic [wvs_pkg::BURST_W-1:0]  burst_ticks,
	input  logic [wvs_pkg::PRIO_W-1:0]   priority_level,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wvs_pkg::KIND_W-1:0]   slot_kind,
	output logic [wvs_pkg::ID_W-1:0]     run_id,
	output logic                         last_of_run,
	input  logic                         cfg_wr_en,
	input  logic [wvs_pkg::OVL_W-1:0]    cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_PROCS);

	wvs_pkg::tok_t              tok_chain  [MAX_PROCS+1];
	logic [IDX_W-1:0]           best_chain [MAX_PROCS+1];
	logic [IDX_W-1:0]           free_chain [MAX_PROCS+1];
	wvs_pkg::cmd_t              cmd;
	logic [IDX_W-1:0]           cmd_idx;
	logic [wvs_pkg::SEQ_W-1:0]  seq_now;

	assign best_chain[0] = '0;
	assign free_chain[0] = '0;

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		wvs_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.tok_in       (tok_chain[i]),
			.best_idx_in  (best_chain[i]),
			.free_idx_in  (free_chain[i]),
			.tok_out      (tok_chain[i+1]),
			.best_idx_out (best_chain[i+1]),
			.free_idx_out (free_chain[i+1]),
			.seq_now      (seq_now),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx)
		);
	end

	wvs_ctrl #(
		.IDX_W         (IDX_W),
		.VRT_FRAC_BITS (VRT_FRAC_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.proc_id        (proc_id),
		.burst_ticks    (burst_ticks),
		.priority_level (priority_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_kind      (slot_kind),
		.run_id         (run_id),
		.last_of_run    (last_of_run),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.tok_start      (tok_chain[0]),
		.tok_end        (tok_chain[MAX_PROCS]),
		.best_idx_end   (best_chain[MAX_PROCS]),
		.free_idx_end   (free_chain[MAX_PROCS]),
		.cmd            (cmd),
		.cmd_idx        (cmd_idx),
		.seq_now        (seq_now)
	);

endmodule

// ----- hw/rtl/wvs_checker.sv -----
module wvs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [wvs_pkg::KIND_W-1:0]  slot_kind,
	input logic [wvs_pkg::ID_W-1:0]    run_id,
	input logic                        last_of_run
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_kind) && $stable(run_id)
			&& $stable(last_of_run))
		else $error("stalled result changed");

	// a transfer starts a sweep
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken during sweep");

	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((slot_kind == wvs_pkg::KIND_IDLE) || (slot_kind == wvs_pkg::KIND_OVL))
			|-> run_id == '0)
		else $error("idle or overload slot with nonzero id");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((slot_kind == wvs_pkg::KIND_IDLE) || (slot_kind == wvs_pkg::KIND_RUN)
			|| (slot_kind == wvs_pkg::KIND_FULL)) |-> last_of_run)
		else $error("single result not marked last");

endmodule

bind weighted_vruntime_scheduler wvs_checker u_wvs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.slot_kind   (slot_kind),
	.run_id      (run_id),
	.last_of_run (last_of_run)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int ID_W    = wvs_pkg::ID_W;
	localparam int BURST_W = wvs_pkg::BURST_W;
	localparam int PRIO_W  = wvs_pkg::PRIO_W;
	localparam int VRT_W   = wvs_pkg::VRT_W;
	localparam int SEQ_W   = wvs_pkg::SEQ_W;
	localparam int TICK_W  = wvs_pkg::TICK_W;
	localparam int KIND_W  = wvs_pkg::KIND_W;
	localparam int OVL_W   = wvs_pkg::OVL_W;

	localparam logic [VRT_W-1:0]  VRT_MAX    = wvs_pkg::VRT_MAX;
	localparam logic [KIND_W-1:0] KIND_IDLE  = wvs_pkg::KIND_IDLE;
	localparam logic [KIND_W-1:0] KIND_RUN   = wvs_pkg::KIND_RUN;
	localparam logic [KIND_W-1:0] KIND_OVL   = wvs_pkg::KIND_OVL;
	localparam logic [KIND_W-1:0] KIND_FULL  = wvs_pkg::KIND_FULL;
	localparam logic              MODE_ADMIT = wvs_pkg::MODE_ADMIT;
	localparam logic              MODE_TICK  = wvs_pkg::MODE_TICK;

	localparam int MAXP    = wvs_pkg::MAX_PROCS_DEF;
	localparam int FRAC    = wvs_pkg::VRT_FRAC_DEF;
	localparam int MAX_RES = 15;
	localparam int SETTLE  = 2 * (MAXP + 2) + 20;
	localparam int LIMIT   = 500000;
	localparam int N_PHASE = 5;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic              last;
	} slot_t;

	typedef struct packed {
		logic               m;
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [4:0]         reps;
		logic               typed;
		logic [KIND_W-1:0]  kind;
		logic [ID_W-1:0]    rid;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = MODE_TICK;
	logic [ID_W-1:0] proc_id = '0;
	logic [BURST_W-1:0] burst_ticks = '0;
	logic [PRIO_W-1:0] priority_level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [KIND_W-1:0] slot_kind;
	logic [ID_W-1:0] run_id;
	logic last_of_run;
	logic cfg_wr_en = 1'b0;
	logic [OVL_W-1:0] cfg_wr_data = '0;

	// scheduler image
	logic [TICK_W-1:0]  tick_ctr;
	logic               ent_vld [MAXP];
	logic [ID_W-1:0]    ent_id [MAXP];
	logic [BURST_W-1:0] ent_left [MAXP];
	logic [PRIO_W-1:0]  ent_prio [MAXP];
	logic [VRT_W-1:0]   ent_vr [MAXP];
	logic [SEQ_W-1:0]   ent_seq [MAXP];
	logic [SEQ_W-1:0]   seq_ctr;
	logic [ID_W-1:0]    cur_id;
	logic               cur_vld;
	logic [OVL_W-1:0]   ovl_slots;

	slot_t step_out [MAX_RES];
	int    step_n;
	slot_t due_slots [$];

	int errors = 0;
	int n_admits = 0;
	int n_ticks = 0;
	int n_checked = 0;
	int kind_cnt [4] = '{0, 0, 0, 0};
	int cycles = 0;
	int stall_left = 0;
	logic idle_en = 1'b1;

	int phase_ovl [N_PHASE] = '{15, 1, 0, 7, 3};

	dir_row_t script [17] = '{
		'{MODE_TICK,  8'h5A, 16'hA5A5, 4'h6, 5'd1,  1'b1, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'h00, 16'd2,    4'd0, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'hA5, 16'h5A5A, 4'h9, 5'd1,  1'b1, KIND_RUN,  8'h00},
		'{MODE_TICK,  8'hFF, 16'hFFFF, 4'hF, 5'd1,  1'b1, KIND_RUN,  8'h00},
		'{MODE_TICK,  8'h00, 16'h0000, 4'h0, 5'd1,  1'b1, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'hFF, 16'hFFFF, 4'd15, 5'd1, 1'b0, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'h11, 16'd0,    4'd1, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'h22, 16'd1,    4'd7, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'h3C, 16'h1234, 4'h3, 5'd1,  1'b1, KIND_RUN,  8'hFF},
		'{MODE_TICK,  8'hC3, 16'hEDCB, 4'hC, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'h01, 16'h8000, 4'h8, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'h80, 16'h0001, 4'h1, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'h7E, 16'h7FFE, 4'h7, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'h22, 16'd3,    4'd0, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_TICK,  8'h99, 16'h6666, 4'hA, 5'd1,  1'b0, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'h40, 16'd1,    4'd3, 5'd14, 1'b0, KIND_IDLE, 8'h00},
		'{MODE_ADMIT, 8'hEE, 16'd5,    4'd9, 5'd1,  1'b1, KIND_FULL, 8'hEE}
	};

	weighted_vruntime_scheduler i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.proc_id        (proc_id),
		.burst_ticks    (burst_ticks),
		.priority_level (priority_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.slot_kind      (slot_kind),
		.run_id         (run_id),
		.last_of_run    (last_of_run),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d slots outstanding", cycles, due_slots.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// 1.25^(p-1) in fixed point, rounded half up
	function automatic logic [VRT_W-1:0] vr_weight(input logic [PRIO_W-1:0] p);
		logic [63:0] num;
		logic [63:0] den;
		num = 64'd1 << FRAC;
		den = 64'd1;
		if (p == 0) begin
			num = 64'd4 << FRAC;
			den = 64'd5;
		end else begin
			for (int k = 1; k < int'(p); k++) begin
				num = num * 64'd5;
				den = den * 64'd4;
			end
		end
		return VRT_W'((64'd2 * num + den) / (64'd2 * den));
	endfunction

	task automatic run_scheduler(input logic m, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio);
		int best;
		int slot;
		logic any;
		logic [SEQ_W-1:0] age_i;
		logic [SEQ_W-1:0] age_b;
		logic [VRT_W-1:0] vr0;
		logic [VRT_W-1:0] w;
		best = -1;
		slot = -1;
		any = 1'b0;
		step_n = 0;
		if (m == MODE_ADMIT) begin
			for (int i = 0; i < MAXP; i++) begin
				if (ent_vld[i])
					any = 1'b1;
				else if (slot < 0)
					slot = i;
			end
			if (slot < 0) begin
				step_out[0] = '{KIND_FULL, id, 1'b1};
				step_n = 1;
			end else begin
				vr0 = VRT_W'(tick_ctr);
				if (vr0 > (VRT_MAX >> FRAC))
					vr0 = VRT_MAX;
				else
					vr0 = vr0 << FRAC;
				ent_vld[slot] = 1'b1;
				ent_id[slot] = id;
				ent_left[slot] = burst;
				ent_prio[slot] = prio;
				ent_vr[slot] = vr0;
				ent_seq[slot] = seq_ctr;
				seq_ctr = seq_ctr + SEQ_W'(1);
				if (!any) begin
					cur_id = id;
					cur_vld = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < MAXP; i++) begin
				if (ent_vld[i]) begin
					if (best < 0 || ent_vr[i] < ent_vr[best]) begin
						best = i;
					end else if (ent_vr[i] == ent_vr[best]) begin
						age_i = seq_ctr - ent_seq[i];
						age_b = seq_ctr - ent_seq[best];
						if (age_i > age_b)
							best = i;
					end
				end
			end
			if (best < 0) begin
				step_out[0] = '{KIND_IDLE, 8'h00, 1'b1};
				step_n = 1;
			end else if (!cur_vld || ent_id[best] != cur_id) begin
				for (int n = 0; n < int'(ovl_slots); n++)
					step_out[n] = '{KIND_OVL, 8'h00, 1'(n + 1 == int'(ovl_slots))};
				step_n = int'(ovl_slots);
				cur_id = ent_id[best];
				cur_vld = 1'b1;
			end else begin
				w = vr_weight(ent_prio[best]);
				step_out[0] = '{KIND_RUN, ent_id[best], 1'b1};
				step_n = 1;
				if (ent_vr[best] > VRT_MAX - w)
					ent_vr[best] = VRT_MAX;
				else
					ent_vr[best] = ent_vr[best] + w;
				if (ent_left[best] <= BURST_W'(1)) begin
					ent_left[best] = '0;
					ent_vld[best] = 1'b0;
				end else begin
					ent_left[best] = ent_left[best] - BURST_W'(1);
				end
			end
			tick_ctr = tick_ctr + TICK_W'(1);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic flag_error(input string what);
		errors++;
		if (errors <= 10)
			$display("%s", what);
	endtask

	task automatic push_item(input logic m, input logic [ID_W-1:0] id,
			input logic [BURST_W-1:0] burst, input logic [PRIO_W-1:0] prio,
			input logic typed, input slot_t typed_slot);
		int gap;
		in_valid <= 1'b1;
		mode <= m;
		proc_id <= id;
		burst_ticks <= burst;
		priority_level <= prio;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		run_scheduler(m, id, burst, prio);
		if (typed)
			due_slots.push_back(typed_slot);
		else
			for (int k = 0; k < step_n; k++)
				due_slots.push_back(step_out[k]);
		if (m == MODE_TICK)
			n_ticks++;
		else
			n_admits++;
		gap = idle_en ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic random_admit();
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0] prio;
		int r;
		r = $urandom_range(0, 99);
		// long bursts only with heavy weights, so they do not starve the table
		if (r < 5) begin
			burst = BURST_W'($urandom_range(0, 65535));
			prio = PRIO_W'($urandom_range(12, 15));
		end else if (r < 12) begin
			burst = '0;
			prio = PRIO_W'($urandom_range(0, 15));
		end else begin
			burst = BURST_W'($urandom_range(1, 6));
			prio = PRIO_W'($urandom_range(0, 15));
		end
		push_item(MODE_ADMIT, ID_W'($urandom_range(0, 255)), burst, prio, 1'b0, '0);
	endtask

	task automatic random_tick();
		push_item(MODE_TICK, ID_W'($urandom_range(0, 255)), BURST_W'($urandom_range(0, 65535)),
			PRIO_W'($urandom_range(0, 15)), 1'b0, '0);
	endtask

	task automatic settle_out();
		in_valid <= 1'b0;
		while (due_slots.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_overload(input logic [OVL_W-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		ovl_slots = v;
		cfg_wr_en <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 99) < 35) begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
			stall_left <= $urandom_range(0, 12);
		end
	end

	always @(posedge clk) begin : slot_check
		slot_t want;
		slot_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{slot_kind, run_id, last_of_run};
			if (due_slots.size() == 0) begin
				flag_error($sformatf("unexpected slot: kind %0d id %02h last %0b",
					got.kind, got.id, got.last));
			end else begin
				want = due_slots.pop_front();
				if (got !== want)
					flag_error($sformatf(
						"slot %0d: expected kind %0d id %02h last %0b, got kind %0d id %02h last %0b",
						n_checked, want.kind, want.id, want.last, got.kind, got.id, got.last));
			end
			if (!$isunknown(got.kind))
				kind_cnt[got.kind]++;
			n_checked++;
		end
	end

	initial begin
		slot_t typed_slot;
		int r;
		int phase_end;
		tick_ctr = '0;
		seq_ctr = '0;
		cur_id = '0;
		cur_vld = 1'b0;
		ovl_slots = '0;
		for (int i = 0; i < MAXP; i++) begin
			ent_vld[i] = 1'b0;
			ent_id[i] = '0;
			ent_left[i] = '0;
			ent_prio[i] = '0;
			ent_vr[i] = '0;
			ent_seq[i] = '0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_overload(4'd0);

		for (int row = 0; row < 17; row++) begin
			typed_slot = '{script[row].kind, script[row].rid, 1'b1};
			for (int k = 0; k < int'(script[row].reps); k++)
				push_item(script[row].m, script[row].id + ID_W'(k), script[row].burst,
					script[row].prio + PRIO_W'(k), script[row].typed, typed_slot);
		end

		for (int ph = 0; ph < N_PHASE; ph++) begin
			settle_out();
			set_overload(OVL_W'(phase_ovl[ph]));
			idle_en = (ph != 2);
			phase_end = n_admits + n_ticks + 25;
			while (n_admits + n_ticks < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 75) begin
					repeat ($urandom_range(1, 3)) random_admit();
					repeat ($urandom_range(2, 10)) random_tick();
				end else if (r < 85) begin
					repeat ($urandom_range(1, 5)) random_admit();
				end else if (r < 96) begin
					repeat ($urandom_range(1, 4)) random_tick();
				end else begin
					settle_out();
				end
			end
		end
		idle_en = 1'b1;
		settle_out();

		$display("%0d admits and %0d ticks over %0d overload settings; %0d slots checked",
			n_admits, n_ticks, N_PHASE + 1, n_checked);
		$display("slots seen: %0d idle, %0d run, %0d overload, %0d refused; %0d mismatches",
			kind_cnt[KIND_IDLE], kind_cnt[KIND_RUN], kind_cnt[KIND_OVL], kind_cnt[KIND_FULL],
			errors);
		if (errors == 0 && due_slots.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- weighted_vruntime_scheduler.f -----
hw/rtl/wvs_pkg.sv
hw/rtl/wvs_cell.sv
hw/rtl/wvs_ctrl.sv
hw/rtl/weighted_vruntime_scheduler.sv
hw/rtl/wvs_checker.sv
bench/testbench.sv
